### src/v2c_pkg.sv
// Package for the valid-region 2D correlation block.
// Holds sizes, field widths and the coefficient grid type; no dependencies.
`default_nettype none
package v2c_pkg;
  localparam int KERNEL_MAX = 5;
  localparam int WIDTH_MAX  = 1024;
  localparam int HEIGHT_MAX = 4096;

  localparam int LB_ROWS   = (KERNEL_MAX > 1) ? KERNEL_MAX - 1 : 1;
  localparam int COEF_N    = KERNEL_MAX * KERNEL_MAX;
  localparam int LB_AW     = $clog2(WIDTH_MAX);
  localparam int PIX_W     = 16;
  localparam int PROD_W    = 2 * PIX_W;
  localparam int ROWSUM_W  = PROD_W + 3;
  localparam int SUM_W     = 36;
  localparam int ROW_W     = 12;
  localparam int COL_W     = 10;
  localparam int IDX_W     = 5;
  localparam int KSZ_W     = 3;
  localparam int IW_W      = 11;
  localparam int IH_W      = 13;
  localparam int CFG_AW    = 2;
  localparam int CFG_DW    = 13;

  typedef enum logic [CFG_AW-1:0] {
    REG_KROWS  = 2'd0,
    REG_KCOLS  = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_COEF  = 1'b1
  } item_kind_t;

  typedef logic signed [PIX_W-1:0] pix_t;
  typedef pix_t grid_t [KERNEL_MAX][KERNEL_MAX];
endpackage
`default_nettype wire

### src/v2c_in_if.sv
// Input channel: pixel or coefficient word with valid/ready.
// Depends on v2c_pkg.
`default_nettype none
interface v2c_in_if;
  import v2c_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [PIX_W-1:0] value;
  logic [IDX_W-1:0]        coef_index;
  modport source (output valid, kind, value, coef_index, input ready);
  modport sink   (input valid, kind, value, coef_index, output ready);
endinterface
`default_nettype wire

### src/v2c_out_if.sv
// Result channel: window sum and position with valid/ready.
// Depends on v2c_pkg.
`default_nettype none
interface v2c_out_if;
  import v2c_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] sum;
  logic [ROW_W-1:0]        out_row;
  logic [COL_W-1:0]        out_col;
  logic                    last_output;
  modport source (output valid, sum, out_row, out_col, last_output, input ready);
  modport sink   (input valid, sum, out_row, out_col, last_output, output ready);
endinterface
`default_nettype wire

### src/valid_2d_correlation_top.sv
// Top level of the streaming valid-region 2D correlation.
// Depends on v2c_pkg, v2c_in_if and v2c_out_if.
//
//  port   | dir | word
//  in_ch  | in  | kind, value, coef_index
//  out_ch | out | sum, out_row, out_col, last_output
//  cfg_*  | in  | write enable, register index, data
//
// One word per cycle while no result is held; a pixel's result reaches out_ch through the stage registers.
// The line buffer is one 1024 x 64 memory, read and written back per pixel;
// a same-column read right after a write is forwarded.
// Reset clears control, counters, window and coefficients, not the memory.
// A held result stalls the whole pipeline; otherwise in_ch.ready stays high.
`default_nettype none
module valid_2d_correlation_top (
  input  wire                        clk,
  input  wire                        rst_n,
  v2c_in_if.sink                     in_ch,
  v2c_out_if.source                  out_ch,
  input  wire                        cfg_we,
  input  wire [v2c_pkg::CFG_AW-1:0]  cfg_index,
  input  wire [v2c_pkg::CFG_DW-1:0]  cfg_data
);
  import v2c_pkg::*;

  localparam int LB_DW = LB_ROWS * PIX_W;

  logic [KSZ_W-1:0] krows_r, kcols_r;
  logic [IW_W-1:0]  width_r;
  logic [IH_W-1:0]  height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      krows_r  <= KSZ_W'(3);
      kcols_r  <= KSZ_W'(3);
      width_r  <= IW_W'(1024);
      height_r <= IH_W'(1024);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_KROWS:  krows_r  <= cfg_data[KSZ_W-1:0];
        REG_KCOLS:  kcols_r  <= cfg_data[KSZ_W-1:0];
        REG_WIDTH:  width_r  <= cfg_data[IW_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[IH_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped sizes
  logic [KSZ_W-1:0] kr, kc;
  logic [IW_W-1:0]  w_m1;
  logic [IH_W-1:0]  h_m1;
  always_comb begin
    kr = (krows_r == '0) ? KSZ_W'(1) :
         (krows_r > KSZ_W'(KERNEL_MAX)) ? KSZ_W'(KERNEL_MAX) : krows_r;
    kc = (kcols_r == '0) ? KSZ_W'(1) :
         (kcols_r > KSZ_W'(KERNEL_MAX)) ? KSZ_W'(KERNEL_MAX) : kcols_r;
    w_m1 = (width_r == '0) ? '0 :
           (width_r > IW_W'(WIDTH_MAX)) ? IW_W'(WIDTH_MAX - 1) : width_r - 1'b1;
    h_m1 = (height_r == '0) ? '0 :
           (height_r > IH_W'(HEIGHT_MAX)) ? IH_W'(HEIGHT_MAX - 1) : height_r - 1'b1;
  end

  // pipeline enable: everything moves unless a result is held
  logic en;
  assign en = !(out_ch.valid && !out_ch.ready);
  assign in_ch.ready = en;

  logic acc, acc_pix, acc_coef;
  assign acc      = in_ch.valid && en;
  assign acc_pix  = acc && (item_kind_t'(in_ch.kind) == KIND_PIXEL);
  assign acc_coef = acc && (item_kind_t'(in_ch.kind) == KIND_COEF);

  // raster position
  logic [ROW_W-1:0] prow_r;
  logic [COL_W-1:0] pcol_r;
  logic row_end, frame_end, emit;
  assign row_end   = {1'b0, pcol_r} >= w_m1;
  assign frame_end = row_end && ({1'b0, prow_r} >= h_m1);
  assign emit      = (prow_r >= ROW_W'(kr - 1'b1)) && (pcol_r >= COL_W'(kc - 1'b1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prow_r <= '0;
      pcol_r <= '0;
    end else if (acc_pix) begin
      if (frame_end) begin
        prow_r <= '0;
        pcol_r <= '0;
      end else if (row_end) begin
        prow_r <= prow_r + 1'b1;
        pcol_r <= '0;
      end else begin
        pcol_r <= pcol_r + 1'b1;
      end
    end
  end

  // stage 1: line buffer read under way
  logic                s1_pix_r, s1_coef_r, s1_emit_r, s1_last_r;
  pix_t                s1_val_r;
  logic [LB_AW-1:0]    s1_addr_r;
  logic [IDX_W-1:0]    s1_idx_r;
  logic [ROW_W-1:0]    s1_row_r;
  logic [COL_W-1:0]    s1_col_r;
  logic [LB_DW-1:0]    lb_mem [WIDTH_MAX];
  logic [LB_DW-1:0]    lb_q_r, fwd_d_r, lb_rd, lb_wd;
  logic                fwd_r;
  logic                coef_ok;

  assign coef_ok = {1'b0, in_ch.coef_index} < (IDX_W + 1)'(kr * kc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_pix_r  <= 1'b0;
      s1_coef_r <= 1'b0;
      fwd_r     <= 1'b0;
    end else if (en) begin
      s1_pix_r  <= acc_pix;
      s1_coef_r <= acc_coef && coef_ok;
      fwd_r     <= acc_pix && s1_pix_r && (s1_addr_r == LB_AW'(pcol_r));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_val_r  <= in_ch.value;
      s1_addr_r <= LB_AW'(pcol_r);
      s1_idx_r  <= in_ch.coef_index;
      s1_emit_r <= emit;
      s1_last_r <= frame_end;
      s1_row_r  <= prow_r - ROW_W'(kr - 1'b1);
      s1_col_r  <= pcol_r - COL_W'(kc - 1'b1);
      fwd_d_r   <= lb_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_pix) lb_q_r <= lb_mem[LB_AW'(pcol_r)];
    if (en && s1_pix_r) lb_mem[s1_addr_r] <= lb_wd;
  end

  // buffer row 0 holds the newest line; shift older rows up
  assign lb_rd = fwd_r ? fwd_d_r : lb_q_r;
  generate
    if (LB_ROWS > 1) begin : g_lbs
      assign lb_wd = {lb_rd[LB_DW-PIX_W-1:0], s1_val_r};
    end else begin : g_lb1
      assign lb_wd = s1_val_r;
    end
  endgenerate

  // coefficient store and grid
  pix_t  coef_r [COEF_N];
  grid_t grid_r, grid_c;
  logic  act_c [KERNEL_MAX][KERNEL_MAX];
  logic  act_r [KERNEL_MAX][KERNEL_MAX];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < COEF_N; n++) coef_r[n] <= '0;
    end else if (en && s1_coef_r) begin
      coef_r[s1_idx_r] <= s1_val_r;
    end
  end

  always_comb begin
    logic [KSZ_W-1:0] offr, offc, k, l;
    logic [IDX_W-1:0] idx;
    offr = KSZ_W'(KERNEL_MAX) - kr;
    offc = KSZ_W'(KERNEL_MAX) - kc;
    for (int i = 0; i < KERNEL_MAX; i++) begin
      for (int j = 0; j < KERNEL_MAX; j++) begin
        k   = KSZ_W'(i) - offr;
        l   = KSZ_W'(j) - offc;
        idx = IDX_W'(k * kc) + IDX_W'(l);
        act_c[i][j] = (KSZ_W'(i) >= offr) && (KSZ_W'(j) >= offc);
        if (act_c[i][j])
          grid_c[i][j] = coef_r[idx];
        else
          grid_c[i][j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KERNEL_MAX; i++)
        for (int j = 0; j < KERNEL_MAX; j++) begin
          grid_r[i][j] <= '0;
          act_r[i][j]  <= 1'b0;
        end
    end else if (en) begin
      grid_r <= grid_c;
      act_r  <= act_c;
    end
  end

  // stage 2: window shift
  grid_t            win_r;
  pix_t             colv [KERNEL_MAX];
  logic             s2_v_r, s2_last_r;
  logic [ROW_W-1:0] s2_row_r;
  logic [COL_W-1:0] s2_col_r;

  always_comb begin
    colv[KERNEL_MAX-1] = s1_val_r;
    for (int i = 0; i < KERNEL_MAX - 1; i++)
      colv[KERNEL_MAX-2-i] = lb_rd[i*PIX_W +: PIX_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KERNEL_MAX; i++)
        for (int j = 0; j < KERNEL_MAX; j++) win_r[i][j] <= '0;
    end else if (en && s1_pix_r) begin
      for (int i = 0; i < KERNEL_MAX; i++) begin
        for (int j = 0; j < KERNEL_MAX - 1; j++) win_r[i][j] <= win_r[i][j+1];
        win_r[i][KERNEL_MAX-1] <= colv[i];
      end
    end
  end

  // stage 3: products, stage 4: row sums, then output
  logic signed [PROD_W-1:0]   prod_r [KERNEL_MAX][KERNEL_MAX];
  logic signed [ROWSUM_W-1:0] rsum_r [KERNEL_MAX];
  logic signed [ROWSUM_W-1:0] rsum_c [KERNEL_MAX];
  logic signed [SUM_W-1:0]    total_c;
  logic             s3_v_r, s3_last_r, s4_v_r, s4_last_r;
  logic [ROW_W-1:0] s3_row_r, s4_row_r;
  logic [COL_W-1:0] s3_col_r, s4_col_r;

  always_comb begin
    total_c = '0;
    for (int i = 0; i < KERNEL_MAX; i++) begin
      rsum_c[i] = '0;
      for (int j = 0; j < KERNEL_MAX; j++)
        rsum_c[i] = rsum_c[i] + ROWSUM_W'(prod_r[i][j]);
      total_c = total_c + SUM_W'(rsum_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r       <= 1'b0;
      s3_v_r       <= 1'b0;
      s4_v_r       <= 1'b0;
      out_ch.valid <= 1'b0;
    end else if (en) begin
      s2_v_r       <= s1_pix_r && s1_emit_r;
      s3_v_r       <= s2_v_r;
      s4_v_r       <= s3_v_r;
      out_ch.valid <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_last_r <= s1_last_r;
      s2_row_r  <= s1_row_r;
      s2_col_r  <= s1_col_r;
      // taps outside the kernel may hold never-written buffer data
      for (int i = 0; i < KERNEL_MAX; i++)
        for (int j = 0; j < KERNEL_MAX; j++)
          if (act_r[i][j]) prod_r[i][j] <= grid_r[i][j] * win_r[i][j];
          else prod_r[i][j] <= '0;
      s3_last_r <= s2_last_r;
      s3_row_r  <= s2_row_r;
      s3_col_r  <= s2_col_r;
      rsum_r    <= rsum_c;
      s4_last_r <= s3_last_r;
      s4_row_r  <= s3_row_r;
      s4_col_r  <= s3_col_r;
      out_ch.sum         <= total_c;
      out_ch.out_row     <= s4_row_r;
      out_ch.out_col     <= s4_col_r;
      out_ch.last_output <= s4_last_r;
    end
  end
endmodule
`default_nettype wire

### src/v2c_checker.sv
// Port-level checks for the correlation top level, bound to it below.
// Depends on v2c_pkg and valid_2d_correlation_top.
`default_nettype none
module v2c_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_ready,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire [v2c_pkg::SUM_W-1:0]   sum,
  input wire [v2c_pkg::ROW_W-1:0]   out_row,
  input wire [v2c_pkg::COL_W-1:0]   out_col
);
  import v2c_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(sum) && $stable(out_row)
                                && $stable(out_col))
    else $error("result word changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held result");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({sum, out_row, out_col}))
    else $error("result word has unknown bits");
endmodule

bind valid_2d_correlation_top v2c_checker u_v2c_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .sum       (out_ch.sum),
  .out_row   (out_ch.out_row),
  .out_col   (out_ch.out_col)
);
`default_nettype wire

### tb/sv/v2c_window_checker.sv
// Checker for the valid-region 2D correlation block: predicts window sums from
// the observed input words and config writes, and compares the result channel.
// Depends on v2c_pkg, v2c_in_if and v2c_out_if.
`default_nettype none
module v2c_window_checker
  import v2c_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  v2c_in_if                  in_ch,
  v2c_out_if                 out_ch,
  input  wire                cfg_we,
  input  wire [CFG_AW-1:0]   cfg_index,
  input  wire [CFG_DW-1:0]   cfg_data,
  output int                 mismatches,
  output int                 pending
);

  typedef struct {
    logic signed [SUM_W-1:0] sum;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic                    last;
  } window_sum_t;

  window_sum_t sums_due[$];

  logic [KSZ_W-1:0] krows_reg, kcols_reg;
  logic [IW_W-1:0]  width_reg;
  logic [IH_W-1:0]  height_reg;
  pix_t             coef_grid [COEF_N];
  pix_t             line_mem  [LB_ROWS][WIDTH_MAX];
  pix_t             win       [KERNEL_MAX][KERNEL_MAX];
  int               cur_row, cur_col;
  int               bad_count;

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic report_miss(string what, longint got, longint want);
    $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
    bad_count++;
  endtask

  task automatic predict_word(logic kind, pix_t value, logic [IDX_W-1:0] idx);
    int          kr, kc, w, h, c;
    pix_t        column [KERNEL_MAX];
    bit          row_end, frame_end;
    longint      acc;
    window_sum_t res;
    kr = clip(krows_reg, 1, KERNEL_MAX);
    kc = clip(kcols_reg, 1, KERNEL_MAX);
    w  = clip(width_reg, 1, WIDTH_MAX);
    h  = clip(height_reg, 1, HEIGHT_MAX);
    if (kind == KIND_COEF) begin
      // indexes past the kernel in use are dropped
      if (idx < kr * kc) coef_grid[idx] = value;
      return;
    end
    c = cur_col % WIDTH_MAX;
    column[KERNEL_MAX-1] = value;
    for (int i = 0; i < KERNEL_MAX - 1; i++) column[KERNEL_MAX-2-i] = line_mem[i][c];
    for (int i = LB_ROWS - 1; i > 0; i--) line_mem[i][c] = line_mem[i-1][c];
    line_mem[0][c] = value;
    for (int i = 0; i < KERNEL_MAX; i++) begin
      for (int j = 0; j < KERNEL_MAX - 1; j++) win[i][j] = win[i][j+1];
      win[i][KERNEL_MAX-1] = column[i];
    end
    row_end   = cur_col >= w - 1;
    frame_end = row_end && (cur_row >= h - 1);
    if (cur_row >= kr - 1 && cur_col >= kc - 1) begin
      acc = 0;
      for (int k = 0; k < kr; k++)
        for (int l = 0; l < kc; l++)
          acc += longint'(coef_grid[k*kc+l]) *
                 longint'(win[KERNEL_MAX-kr+k][KERNEL_MAX-kc+l]);
      if (acc > 64'sd34359738367) acc = 64'sd34359738367;
      if (acc < -64'sd34359738368) acc = -64'sd34359738368;
      res.sum  = acc[SUM_W-1:0];
      res.row  = ROW_W'(cur_row - (kr - 1));
      res.col  = COL_W'(cur_col - (kc - 1));
      res.last = frame_end;
      sums_due = {sums_due, res};
    end
    if (frame_end) begin
      cur_row = 0;
      cur_col = 0;
    end else if (row_end) begin
      cur_row++;
      cur_col = 0;
    end else begin
      cur_col++;
    end
  endtask

  task automatic check_result();
    window_sum_t want;
    if (sums_due.size() == 0) begin
      report_miss("unexpected word, sum", out_ch.sum, 0);
      return;
    end
    want = sums_due.pop_front();
    if (out_ch.sum !== want.sum) report_miss("sum", out_ch.sum, want.sum);
    if (out_ch.out_row !== want.row) report_miss("out_row", out_ch.out_row, want.row);
    if (out_ch.out_col !== want.col) report_miss("out_col", out_ch.out_col, want.col);
    if (out_ch.last_output !== want.last)
      report_miss("last_output", out_ch.last_output, want.last);
  endtask

  initial bad_count = 0;
  assign mismatches = bad_count;

  always @(posedge clk) begin
    if (!rst_n) begin
      krows_reg  = 3;
      kcols_reg  = 3;
      width_reg  = 1024;
      height_reg = 1024;
      cur_row    = 0;
      cur_col    = 0;
      foreach (coef_grid[i]) coef_grid[i] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      foreach (line_mem[i, j]) line_mem[i][j] = '0;
      sums_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_KROWS:  krows_reg  = cfg_data[KSZ_W-1:0];
          REG_KCOLS:  kcols_reg  = cfg_data[KSZ_W-1:0];
          REG_WIDTH:  width_reg  = cfg_data[IW_W-1:0];
          REG_HEIGHT: height_reg = cfg_data[IH_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) predict_word(in_ch.kind, in_ch.value, in_ch.coef_index);
      if (out_ch.valid && out_ch.ready) check_result();
    end
    pending <= sums_due.size();
  end

endmodule
`default_nettype wire

### tb/sv/valid_2d_correlation_top_tb.sv
// Testbench top for valid_2d_correlation_top: drives coefficient and pixel
// frames under several register settings, with random stalls on both sides.
// Depends on v2c_pkg, both channel interfaces and v2c_window_checker.
`default_nettype none
module valid_2d_correlation_top_tb;
  import v2c_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  int                mismatches, pending;
  logic              idle_on;
  logic              hold_kick, kick_seen;
  int                hold_left;
  int                kr_now, kc_now, w_now, h_now;
  int                words_sent;

  v2c_in_if  in_ch ();
  v2c_out_if out_ch ();

  valid_2d_correlation_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  v2c_window_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // result-side ready: random stalls, plus a long hold-off on each kick
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      kick_seen    <= 1'b0;
    end else if (hold_kick != kick_seen) begin
      kick_seen    <= hold_kick;
      hold_left    <= 300;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= idle_on ? ($urandom_range(99) >= 19) : 1'b1;
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic pix_t rand_word16();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return -16'sd1;
      default: return pix_t'($urandom);
    endcase
  endfunction

  task automatic put_word(item_kind_t kind, pix_t value, logic [IDX_W-1:0] idx);
    if (idle_on) begin
      while ($urandom_range(99) < 19) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.value      <= value;
    in_ch.coef_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  // block idle: every result back, then margin for words that make none
  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_regs(int kr, int kc, int w, int h);
    in_ch.valid <= 1'b0;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_KROWS;
    cfg_data  <= CFG_DW'(kr);
    @(posedge clk);
    cfg_index <= REG_KCOLS;
    cfg_data  <= CFG_DW'(kc);
    @(posedge clk);
    cfg_index <= REG_WIDTH;
    cfg_data  <= CFG_DW'(w);
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= CFG_DW'(h);
    @(posedge clk);
    cfg_we    <= 1'b0;
    kr_now = clip(kr & 7, 1, KERNEL_MAX);
    kc_now = clip(kc & 7, 1, KERNEL_MAX);
    w_now  = clip(w & 'h7ff, 1, WIDTH_MAX);
    h_now  = clip(h & 'h1fff, 1, HEIGHT_MAX);
  endtask

  task automatic load_kernel(bit pinned, pix_t pin_val);
    for (int i = 0; i < kr_now * kc_now; i++)
      put_word(KIND_COEF, pinned ? pin_val : rand_word16(), IDX_W'(i));
  endtask

  // one whole frame; unless pinned, a few coefficient words slip in between pixels
  task automatic send_frame(bit pinned, pix_t pin_val);
    for (int r = 0; r < h_now; r++)
      for (int c = 0; c < w_now; c++) begin
        if (!pinned && $urandom_range(99) < 3)
          put_word(KIND_COEF, rand_word16(), IDX_W'($urandom_range(31)));
        put_word(KIND_PIXEL, pinned ? pin_val : rand_word16(), IDX_W'($urandom));
      end
  endtask

  initial begin
    int phase;
    int kr, kc, w, h;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_KROWS;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_PIXEL;
    in_ch.value      = '0;
    in_ch.coef_index = '0;
    idle_on          = 1'b1;
    hold_kick        = 1'b0;
    words_sent       = 0;
    kr_now = 3;
    kc_now = 3;
    w_now  = 1024;
    h_now  = 1024;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // coefficients under the reset 3x3 size, plus indexes past the kernel
    put_word(KIND_COEF, 16'sh7fff, 5'd0);
    put_word(KIND_COEF, 16'sh8000, 5'd4);
    put_word(KIND_COEF, 16'sh4000, 5'd8);
    put_word(KIND_COEF, 16'sh1234, 5'd9);
    put_word(KIND_COEF, 16'sh5555, 5'd31);
    set_regs(3, 3, 4, 3);
    send_frame(1'b0, '0);

    // full 5x5 kernel exactly fitting the image: largest positive sum
    set_regs(5, 5, 5, 5);
    load_kernel(1'b1, 16'sh8000);
    send_frame(1'b1, 16'sh8000);

    // sizes beyond range saturate; kernel taller than the single row: no results
    set_regs(7, 0, 2047, 0);
    send_frame(1'b0, '0);

    // 1x1 kernel on a one-pixel-wide image: same column back to back
    set_regs(0, 0, 0, 20);
    load_kernel(1'b0, '0);
    send_frame(1'b0, '0);

    phase = 0;
    while (words_sent < 1950) begin
      kr = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(1, 5);
      kc = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(1, 5);
      w  = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 14);
      h  = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 12);
      set_regs(kr, kc, w, h);
      idle_on <= !(phase >= 4 && phase < 9);
      load_kernel(1'b0, '0);
      if (phase % 10 == 2) begin
        in_ch.valid <= 1'b0;
        wait_drained();
        w_now = 14;
        h_now = 12;
        cfg_we    <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data  <= CFG_DW'(14);
        @(posedge clk);
        cfg_index <= REG_HEIGHT;
        cfg_data  <= CFG_DW'(12);
        @(posedge clk);
        cfg_we    <= 1'b0;
        hold_kick <= ~hold_kick;
      end
      send_frame(1'b0, '0);
      phase++;
    end

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
